// ===== hw/rtl/gbbs_pkg.sv =====
// Shared types and codes for the greedy breadth buffer sharing block.
// No dependencies; used by every other file under hw/rtl except gbbs_ram.
`timescale 1ns / 1ps
package gbbs_pkg;

    localparam int SIZE_W = 32;
    localparam int USE_W  = 16;
    localparam int ID_W   = 10;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_REUSED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STAT_W-1:0] ST_PLACED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SLOT = 3'd3;
    localparam logic [STAT_W-1:0] ST_IV_FULL = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED = 3'd5;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // broadcast from the controller to every chunk cell
    typedef struct packed {
        logic              clr;       // empty the chunk
        logic              scan_clr;  // start a new overlap scan
        logic              scan_rd;   // interval read issued this cycle
        logic              wr;        // commit the item to the addressed cell
        logic [USE_W-1:0]  first;
        logic [USE_W-1:0]  last;
        logic [SIZE_W-1:0] size;
    } t_cell_cmd;

    // best-so-far token handed from cell to cell
    typedef struct packed {
        logic              have;
        logic [SIZE_W-1:0] bsize;
    } t_link;

endpackage

// ===== hw/rtl/greedy_breadth_buffer_sharing.sv =====
// Top level of the greedy breadth buffer sharing block: controller, mark RAM,
// chain of chunk cells. Depends on gbbs_pkg, gbbs_ram and gbbs_cell.
//
// Usage
//   Slave stream: one item per tensor usage. s_axis_tuser is the command
//   (place or clear), s_axis_tdata carries id, size, first and last use.
//   Master stream: one result item per input item. m_axis_tuser is the
//   status, m_axis_tdata the chunk index, chunk bytes and chunks in use.
// Operation
//   A place item first wraps its id into the mark range (subtracting
//   MAX_TENSORS until it fits, not at all when the id already fits), reads its
//   placed mark, scans all interval RAMs in parallel, walks the best-fit
//   token down the chain of MAX_CHUNKS cells, commits and hands the result
//   to the output register.
//   An id already placed returns straight after its mark read.
//   A clear item sweeps the mark RAM.
//   One item is worked on at a time; the next is taken once the result
//   has moved to the output register.
// Reset
//   Reset empties all chunks and runs the same sweep of the mark RAM
//   with s_axis_tready low.
// Stall
//   A result waits in the output register until m_axis_tready; a finished
//   item behind it holds in the controller.
`timescale 1ns / 1ps
module greedy_breadth_buffer_sharing #(
    parameter int MAX_CHUNKS    = 16,
    parameter int MAX_INTERVALS = 16,
    parameter int MAX_TENSORS   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // tensor_id[9:0], size[41:10],
                                       // first_use[57:42], last_use[73:58], zero
    input  logic        s_axis_tuser,  // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // chunk_index[3:0], chunk_bytes[35:4],
                                       // chunks_used[40:36], zero
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    localparam int CIW = MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNW = $clog2(MAX_CHUNKS + 1);
    localparam int IW  = MAX_INTERVALS > 1 ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW  = $clog2(MAX_INTERVALS + 1);
    localparam int TW  = $clog2(MAX_TENSORS);

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_MRD    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_CHN    = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]  r_state;
    logic [TW-1:0] r_sw;
    logic        r_clr_res;
    logic [CNW-1:0] r_count;
    logic [CW-1:0]  r_k;
    logic [CIW-1:0] r_j;

    // item fields
    logic [gbbs_pkg::ID_W-1:0]   r_id;
    logic [gbbs_pkg::SIZE_W-1:0] r_size;
    logic [gbbs_pkg::USE_W-1:0]  r_first;
    logic [gbbs_pkg::USE_W-1:0]  r_last;

    // pending result and output register
    logic [gbbs_pkg::STAT_W-1:0] r_res_stat;
    logic [3:0]                  r_res_idx;
    logic [gbbs_pkg::SIZE_W-1:0] r_res_bytes;
    logic [4:0]                  r_res_used;
    logic                        r_ov;
    logic [gbbs_pkg::STAT_W-1:0] r_o_stat;
    logic [3:0]                  r_o_idx;
    logic [gbbs_pkg::SIZE_W-1:0] r_o_bytes;
    logic [4:0]                  r_o_used;

    logic                  w_acc;
    logic                  w_load;
    logic                  w_mark_we;
    logic [TW-1:0]         w_mark_waddr;
    logic                  w_mark_wdata;
    logic                  w_mark_q;
    gbbs_pkg::t_cell_cmd   w_cmd;
    logic [CIW-1:0]        w_wr_idx;
    logic                  w_id_big;

    gbbs_pkg::t_link       w_link [MAX_CHUNKS+1];
    logic [CIW-1:0]        w_bidx [MAX_CHUNKS+1];
    logic [CW-1:0]         w_bcnt [MAX_CHUNKS+1];

    logic                  w_fin_have;
    logic [gbbs_pkg::SIZE_W-1:0] w_fin_bsize;
    logic [CIW-1:0]        w_fin_idx;
    logic [CW-1:0]         w_fin_cnt;
    logic [gbbs_pkg::SIZE_W-1:0] w_grown;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_load = (r_state == S_FIN) && (!r_ov || m_axis_tready);
    assign w_id_big = {7'd0, r_id} >= 17'(MAX_TENSORS);

    // placed marks, one bit per tensor id
    gbbs_ram #(.WIDTH(1), .DEPTH(MAX_TENSORS)) u_marks (
        .i_clk  (i_clk),
        .i_we   (w_mark_we),
        .i_waddr(w_mark_waddr),
        .i_wdata(w_mark_wdata),
        .i_raddr(TW'(r_id)),
        .o_rdata(w_mark_q)
    );

    // chain of chunk cells
    assign w_link[0] = '{have: 1'b0, bsize: '0};
    assign w_bidx[0] = '0;
    assign w_bcnt[0] = '0;

    for (genvar c = 0; c < MAX_CHUNKS; c++) begin : g_cell
        gbbs_cell #(
            .IDX          (c),
            .MAX_CHUNKS   (MAX_CHUNKS),
            .MAX_INTERVALS(MAX_INTERVALS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_wr_idx  (w_wr_idx),
            .i_rd_addr (r_k[IW-1:0]),
            .i_link    (w_link[c]),
            .i_best_idx(w_bidx[c]),
            .i_best_cnt(w_bcnt[c]),
            .o_link    (w_link[c+1]),
            .o_best_idx(w_bidx[c+1]),
            .o_best_cnt(w_bcnt[c+1])
        );
    end

    assign w_fin_have  = w_link[MAX_CHUNKS].have;
    assign w_fin_bsize = w_link[MAX_CHUNKS].bsize;
    assign w_fin_idx   = w_bidx[MAX_CHUNKS];
    assign w_fin_cnt   = w_bcnt[MAX_CHUNKS];
    assign w_grown     = (w_fin_bsize < r_size) ? r_size : w_fin_bsize;

    // commit goes to the best cell, or to the next free one
    assign w_wr_idx = w_fin_have ? w_fin_idx : CIW'(r_count);

    always_comb begin
        w_cmd.clr      = w_acc && (s_axis_tuser == gbbs_pkg::CMD_CLEAR);
        w_cmd.scan_clr = (r_state == S_MRD);
        w_cmd.scan_rd  = (r_state == S_SCAN) && (r_k != CW'(MAX_INTERVALS));
        w_cmd.wr       = 1'b0;
        w_cmd.first    = r_first;
        w_cmd.last     = r_last;
        w_cmd.size     = r_size;
        w_mark_we      = 1'b0;
        w_mark_waddr   = r_sw;
        w_mark_wdata   = 1'b0;
        if (r_state == S_CLR) begin
            w_mark_we = 1'b1;
        end else if (r_state == S_COMMIT) begin
            w_mark_waddr = TW'(r_id);
            w_mark_wdata = 1'b1;
            if (w_fin_have) begin
                w_cmd.wr  = (w_fin_cnt != CW'(MAX_INTERVALS));
                w_mark_we = w_cmd.wr;
            end else begin
                w_cmd.wr  = (r_count != CNW'(MAX_CHUNKS));
                w_mark_we = w_cmd.wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_sw      <= '0;
            r_clr_res <= 1'b0;
            r_count   <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == TW'(MAX_TENSORS - 1)) begin
                        r_state <= r_clr_res ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        if (s_axis_tuser == gbbs_pkg::CMD_CLEAR) begin
                            r_count   <= '0;
                            r_sw      <= '0;
                            r_clr_res <= 1'b1;
                            r_state   <= S_CLR;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (!w_id_big) begin
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    r_state <= w_mark_q ? S_FIN : S_SCAN;
                end
                S_SCAN: begin
                    if (r_k == CW'(MAX_INTERVALS)) begin
                        r_state <= S_CHN;
                    end
                end
                S_CHN: begin
                    if (r_j == CIW'(MAX_CHUNKS - 1)) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    if (!w_fin_have && w_cmd.wr) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_id    <= s_axis_tdata[9:0];
            r_size  <= s_axis_tdata[41:10];
            r_first <= s_axis_tdata[57:42];
            r_last  <= s_axis_tdata[73:58];
        end else if (r_state == S_MOD && w_id_big) begin
            r_id <= r_id - gbbs_pkg::ID_W'(MAX_TENSORS);
        end
        if (r_state == S_MRD) begin
            r_k <= '0;
        end else if (r_state == S_SCAN) begin
            r_k <= r_k + 1'b1;
        end
        if (r_state == S_SCAN) begin
            r_j <= '0;
        end else if (r_state == S_CHN) begin
            r_j <= r_j + 1'b1;
        end

        if (r_state == S_CLR) begin
            r_res_stat  <= gbbs_pkg::ST_CLEARED;
            r_res_idx   <= '0;
            r_res_bytes <= '0;
            r_res_used  <= '0;
        end else if (r_state == S_MRD) begin
            r_res_stat  <= gbbs_pkg::ST_PLACED;
            r_res_idx   <= '0;
            r_res_bytes <= '0;
            r_res_used  <= 5'(r_count);
        end else if (r_state == S_COMMIT) begin
            r_res_idx   <= '0;
            r_res_bytes <= '0;
            r_res_used  <= 5'(r_count);
            if (!w_fin_have) begin
                if (r_count == CNW'(MAX_CHUNKS)) begin
                    r_res_stat <= gbbs_pkg::ST_NO_SLOT;
                end else begin
                    r_res_stat  <= gbbs_pkg::ST_NEW;
                    r_res_idx   <= 4'(r_count);
                    r_res_bytes <= r_size;
                    r_res_used  <= 5'(r_count + 1'b1);
                end
            end else if (w_fin_cnt == CW'(MAX_INTERVALS)) begin
                r_res_stat <= gbbs_pkg::ST_IV_FULL;
            end else begin
                r_res_stat  <= gbbs_pkg::ST_REUSED;
                r_res_idx   <= 4'(w_fin_idx);
                r_res_bytes <= w_grown;
            end
        end

        if (w_load) begin
            r_o_stat  <= r_res_stat;
            r_o_idx   <= r_res_idx;
            r_o_bytes <= r_res_bytes;
            r_o_used  <= r_res_used;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_o_stat;
    assign m_axis_tdata  = {7'd0, r_o_used, r_o_bytes, r_o_idx};
endmodule

// ===== hw/rtl/gbbs_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gbbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/gbbs_cell.sv =====
// One chunk cell: size, interval count, interval RAM, overlap flag, chain stage.
// Depends on gbbs_pkg and gbbs_ram.
`timescale 1ns / 1ps
module gbbs_cell #(
    parameter int IDX           = 0,
    parameter int MAX_CHUNKS    = 16,
    parameter int MAX_INTERVALS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbbs_pkg::t_cell_cmd  i_cmd,
    input  logic [(MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1)-1:0] i_wr_idx,
    input  logic [(MAX_INTERVALS > 1 ? $clog2(MAX_INTERVALS) : 1)-1:0] i_rd_addr,
    input  gbbs_pkg::t_link      i_link,
    input  logic [(MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1)-1:0] i_best_idx,
    input  logic [$clog2(MAX_INTERVALS+1)-1:0] i_best_cnt,
    output gbbs_pkg::t_link      o_link,
    output logic [(MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1)-1:0] o_best_idx,
    output logic [$clog2(MAX_INTERVALS+1)-1:0] o_best_cnt
);
    localparam int CIW = MAX_CHUNKS > 1 ? $clog2(MAX_CHUNKS) : 1;
    localparam int IW  = MAX_INTERVALS > 1 ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW  = $clog2(MAX_INTERVALS + 1);

    logic [gbbs_pkg::SIZE_W-1:0] r_size;
    logic [CW-1:0]               r_cnt;
    logic                        r_ovl;
    logic                        r_acc;
    logic [IW-1:0]               r_kd;
    logic                        r_have;
    logic [gbbs_pkg::SIZE_W-1:0] r_bsize;
    logic [CIW-1:0]              r_best_idx;
    logic [CW-1:0]               r_best_cnt;

    logic [2*gbbs_pkg::USE_W-1:0] w_rdata;
    logic                         w_sel;
    logic                         w_hit;
    logic                         w_better;
    logic                         w_cand;

    gbbs_ram #(.WIDTH(2*gbbs_pkg::USE_W), .DEPTH(MAX_INTERVALS)) u_iv (
        .i_clk  (i_clk),
        .i_we   (w_sel),
        .i_waddr(r_cnt[IW-1:0]),
        .i_wdata({i_cmd.first, i_cmd.last}),
        .i_raddr(i_rd_addr),
        .o_rdata(w_rdata)
    );

    assign w_sel = i_cmd.wr && (i_wr_idx == CIW'(IDX));
    assign w_hit = (i_cmd.first <= w_rdata[gbbs_pkg::USE_W-1:0])
                && (w_rdata[2*gbbs_pkg::USE_W-1:gbbs_pkg::USE_W] <= i_cmd.last);

    // smallest fitting chunk, else largest; earlier cell keeps ties
    always_comb begin
        if (i_link.bsize < i_cmd.size) begin
            w_better = r_size > i_link.bsize;
        end else begin
            w_better = (r_size >= i_cmd.size) && (r_size < i_link.bsize);
        end
    end
    assign w_cand = (r_cnt != '0) && !r_ovl && (!i_link.have || w_better);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_size <= '0;
            r_acc  <= 1'b0;
            r_ovl  <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_acc <= i_cmd.scan_rd;
            if (i_cmd.clr) begin
                r_cnt  <= '0;
                r_size <= '0;
            end else if (w_sel) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_size < i_cmd.size) begin
                    r_size <= i_cmd.size;
                end
            end
            if (i_cmd.scan_clr) begin
                r_ovl <= 1'b0;
            end else if (r_acc && (CW'(r_kd) < r_cnt) && w_hit) begin
                r_ovl <= 1'b1;
            end
            r_have <= i_link.have || w_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd       <= i_rd_addr;
        r_bsize    <= w_cand ? r_size : i_link.bsize;
        r_best_idx <= w_cand ? CIW'(IDX) : i_best_idx;
        r_best_cnt <= w_cand ? r_cnt : i_best_cnt;
    end

    assign o_link     = '{have: r_have, bsize: r_bsize};
    assign o_best_idx = r_best_idx;
    assign o_best_cnt = r_best_cnt;
endmodule

// ===== hw/rtl/gbbs_chk.sv =====
// Port-level checker for greedy_breadth_buffer_sharing, bound to the top level.
// Depends on gbbs_pkg.
`timescale 1ns / 1ps
module gbbs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        s_axis_tready
);
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("outputs active right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_placed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == gbbs_pkg::ST_PLACED
            || m_axis_tuser == gbbs_pkg::ST_NO_SLOT
            || m_axis_tuser == gbbs_pkg::ST_IV_FULL) |-> m_axis_tdata[35:0] == '0)
        else $error("unplaced item reports a chunk");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == gbbs_pkg::ST_CLEARED |-> m_axis_tdata == '0)
        else $error("clear result not zero");

    a_new_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == gbbs_pkg::ST_NEW
            |-> m_axis_tdata[40:36] == 5'(m_axis_tdata[3:0] + 5'd1))
        else $error("new chunk count mismatch");
endmodule

bind greedy_breadth_buffer_sharing gbbs_chk u_gbbs_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .s_axis_tready(s_axis_tready)
);

// ===== test/tb_greedy_breadth_buffer_sharing.sv =====
// Testbench for greedy_breadth_buffer_sharing: directed table then random usages,
// every result checked against a behavioral chunk allocator. Depends on gbbs_pkg.
`timescale 1ns / 1ps
module tb_greedy_breadth_buffer_sharing;

    localparam int N_CHUNKS = 16;
    localparam int N_IVS    = 16;
    localparam int N_IDS    = 1024;
    localparam int N_RANDOM = 530;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        cmd;
        logic [9:0]  id;
        logic [31:0] size;
        logic [15:0] first;
        logic [15:0] last;
    } t_usage;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  idx;
        logic [31:0] bytes;
        logic [4:0]  used;
    } t_alloc;

    typedef struct {
        t_usage u;
        logic   typed;     // expected result given in the table
        t_alloc res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // tensor_id, size, first_use, last_use, zero
    logic        s_axis_tuser = 1'b0; // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // chunk_index, chunk_bytes, chunks_used, zero
    logic [2:0]  m_axis_tuser;        // status

    greedy_breadth_buffer_sharing i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // allocator state mirrored in the bench
    logic [31:0] chunk_bytes_m [N_CHUNKS];
    int          chunks_open;
    logic [15:0] iv_first [N_CHUNKS][N_IVS];
    logic [15:0] iv_last  [N_CHUNKS][N_IVS];
    int          iv_cnt [N_CHUNKS];
    bit          placed [N_IDS];

    t_alloc pending_allocs[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_off = 1'b0;
    longint cycles = 0;
    t_row   table_rows[$];

    function automatic void wipe_allocator();
        for (int c = 0; c < N_CHUNKS; c++) begin
            chunk_bytes_m[c] = '0;
            iv_cnt[c] = 0;
        end
        for (int t = 0; t < N_IDS; t++) placed[t] = 1'b0;
        chunks_open = 0;
    endfunction

    function automatic bit chunk_busy(int c, logic [15:0] f, logic [15:0] l);
        for (int k = 0; k < iv_cnt[c]; k++)
            if (f <= iv_last[c][k] && iv_first[c][k] <= l) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_alloc allocate(t_usage u);
        t_alloc r;
        bit have;
        int best;
        int id;
        r = '{status: gbbs_pkg::ST_PLACED, idx: '0, bytes: '0, used: '0};
        have = 1'b0;
        best = 0;
        id = int'(u.id) % N_IDS;
        if (u.cmd == gbbs_pkg::CMD_CLEAR) begin
            wipe_allocator();
            r.status = gbbs_pkg::ST_CLEARED;
        end else if (!placed[id]) begin
            for (int c = 0; c < chunks_open; c++) begin
                if (have) begin
                    if (chunk_bytes_m[best] < u.size) begin
                        if (chunk_bytes_m[c] <= chunk_bytes_m[best]) continue;
                    end else if (chunk_bytes_m[c] < u.size ||
                                 chunk_bytes_m[c] >= chunk_bytes_m[best]) begin
                        continue;
                    end
                end
                if (chunk_busy(c, u.first, u.last)) continue;
                best = c;
                have = 1'b1;
            end
            if (!have) begin
                if (chunks_open >= N_CHUNKS) begin
                    r.status = gbbs_pkg::ST_NO_SLOT;
                end else begin
                    best = chunks_open;
                    chunk_bytes_m[best] = u.size;
                    iv_first[best][0] = u.first;
                    iv_last[best][0] = u.last;
                    iv_cnt[best] = 1;
                    chunks_open++;
                    placed[id] = 1'b1;
                    r.status = gbbs_pkg::ST_NEW;
                    r.idx = best[3:0];
                    r.bytes = u.size;
                end
            end else if (iv_cnt[best] >= N_IVS) begin
                r.status = gbbs_pkg::ST_IV_FULL;
            end else begin
                if (chunk_bytes_m[best] < u.size) chunk_bytes_m[best] = u.size;
                iv_first[best][iv_cnt[best]] = u.first;
                iv_last[best][iv_cnt[best]] = u.last;
                iv_cnt[best]++;
                placed[id] = 1'b1;
                r.status = gbbs_pkg::ST_REUSED;
                r.idx = best[3:0];
                r.bytes = chunk_bytes_m[best];
            end
        end
        r.used = chunks_open[4:0];
        return r;
    endfunction

    // drive one item at the falling edge, wait for its handshake
    task automatic offer(t_usage u);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= u.cmd;
        s_axis_tdata  <= {6'd0, u.last, u.first, u.size, u.id};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send(t_usage u, bit typed, t_alloc res);
        t_alloc p;
        p = allocate(u);
        if (typed && p != res) begin
            $error("table row status exp %0d got %0d", res.status, p.status);
            errors++;
        end
        pending_allocs.insert(pending_allocs.size(), p);
        offer(u);
    endtask

    // idle the sender, then wait for every result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_allocs.size() != 0) @(negedge i_clk);
    endtask

    function automatic void add_row(t_usage u, bit typed, t_alloc res);
        t_row r;
        r.u = u;
        r.typed = typed;
        r.res = res;
        table_rows.insert(table_rows.size(), r);
    endfunction

    function automatic t_usage place(int id, logic [31:0] sz, int f, int l);
        t_usage u;
        u = '{cmd: gbbs_pkg::CMD_PLACE, id: id[9:0], size: sz, first: f[15:0],
              last: l[15:0]};
        return u;
    endfunction

    function automatic t_usage clear_item();
        t_usage u;
        u = '{cmd: gbbs_pkg::CMD_CLEAR, id: 10'h3FF, size: '1, first: '1, last: '1};
        return u;
    endfunction

    // mostly short lifetimes on a small op range so chunks get shared
    function automatic t_usage rand_usage();
        t_usage u;
        int f;
        int r;
        r = $urandom_range(99);
        f = $urandom_range(200);
        u.cmd = (r < 2) ? gbbs_pkg::CMD_CLEAR : gbbs_pkg::CMD_PLACE;
        u.id = (r < 60) ? 10'($urandom_range(80)) : 10'($urandom);
        case ($urandom_range(3))
            0: u.size = $urandom;
            1: u.size = 32'($urandom_range(4096));
            2: u.size = 32'hFFFF_FFFF - $urandom_range(3);
            default: u.size = 32'($urandom_range(16));
        endcase
        if (r >= 95) begin
            u.first = 16'($urandom);
            u.last = 16'($urandom);
        end else begin
            u.first = f[15:0];
            u.last = 16'(f + $urandom_range(6));
        end
        return u;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_alloc e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_allocs.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                e = pending_allocs.pop_front();
                if (m_axis_tuser !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[3:0] !== e.idx) begin
                    $error("chunk_index exp %0d got %0d", e.idx, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[35:4] !== e.bytes) begin
                    $error("chunk_bytes exp %0h got %0h", e.bytes, m_axis_tdata[35:4]);
                    errors++;
                end
                if (m_axis_tdata[40:36] !== e.used) begin
                    $error("chunks_used exp %0d got %0d", e.used, m_axis_tdata[40:36]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("greedy_breadth_buffer_sharing: mismatch");
            $finish;
        end
    end

    // long receiver stall, counted in its own process
    initial begin
        wait (i_rst_n);
        repeat (3000) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        t_alloc none;
        none = '{status: gbbs_pkg::ST_PLACED, idx: '0, bytes: '0, used: '0};
        wipe_allocator();
        // directed table; typed rows worked out by hand
        add_row(place(5, 32'd100, 0, 3), 1,
                '{gbbs_pkg::ST_NEW, 4'd0, 32'd100, 5'd1});
        add_row(place(5, 32'd100, 0, 3), 1,
                '{gbbs_pkg::ST_PLACED, 4'd0, 32'd0, 5'd1});
        add_row(place(6, 32'd50, 4, 9), 1,
                '{gbbs_pkg::ST_REUSED, 4'd0, 32'd100, 5'd1});
        add_row(place(7, 32'hFFFF_FFFF, 3, 3), 1,
                '{gbbs_pkg::ST_NEW, 4'd1, 32'hFFFF_FFFF, 5'd2});
        add_row(place(1023, 32'd0, 10, 65535), 0, none);
        add_row(place(8, 32'd200, 9, 2), 0, none);  // reversed interval
        add_row(place(9, 32'd1, 65535, 65535), 0, none);
        add_row(place(0, 32'd70, 100, 100), 0, none);
        add_row(clear_item(), 1, '{gbbs_pkg::ST_CLEARED, 4'd0, 32'd0, 5'd0});
        // same interval 17 times fills all 16 chunks, then no slot
        for (int i = 0; i < 17; i++)
            add_row(place(100 + i, 32'(i), 0, 0), 0, none);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[i]) send(table_rows[i].u, table_rows[i].typed, table_rows[i].res);
        drain();
        send(clear_item(), 1'b0, none);
        // one chunk, 17 disjoint usages: interval store full
        for (int i = 0; i < 17; i++) send(place(200 + i, 32'd8, 2 * i, 2 * i), 1'b0, none);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 87 : 0;
            recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 11 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++) send(rand_usage(), 1'b0, none);
            drain();
        end

        repeat (60) @(negedge i_clk);
        if (errors == 0 && pending_allocs.size() == 0)
            $display("greedy_breadth_buffer_sharing: match");
        else
            $display("greedy_breadth_buffer_sharing: mismatch");
        $finish;
    end
endmodule
